// ----- design/ssi_efr_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ssi_efr_pkg;

    localparam int LINES   = 4;
    localparam int TICK_W  = 8;
    localparam int INDEX_W = 8;
    localparam int POS_W   = 12;

    localparam logic [INDEX_W-1:0] CFG_LEAD  = 8'd0;
    localparam logic [INDEX_W-1:0] CFG_HIGH  = 8'd1;
    localparam logic [INDEX_W-1:0] CFG_LOW   = 8'd2;
    localparam logic [INDEX_W-1:0] CFG_GAP   = 8'd3;

    localparam logic [TICK_W-1:0] LEAD_RST = 8'd4;
    localparam logic [TICK_W-1:0] HIGH_RST = 8'd3;
    localparam logic [TICK_W-1:0] LOW_RST  = 8'd2;
    localparam logic [TICK_W-1:0] GAP_RST  = 8'd31;

    typedef struct packed {
        logic             start_req;
        logic [1:0]       channel;
        logic [LINES-1:0] data_pins;
    } in_item_t;

    typedef struct packed {
        logic [LINES-1:0] clock_lines;
        logic [LINES-1:0] select_lines;
        logic             busy_res;
        logic             frame_valid;
        logic [POS_W-1:0] position;
        logic             offset_done;
        logic             linearity_flag;
        logic             field_increase;
        logic             field_decrease;
    } out_item_t;

    typedef struct packed {
        logic [TICK_W-1:0] lead_ticks;
        logic [TICK_W-1:0] clock_high_ticks;
        logic [TICK_W-1:0] clock_low_ticks;
        logic [TICK_W-1:0] gap_ticks;
    } cfg_t;

    // a count of zero behaves as one tick
    function automatic logic [TICK_W-1:0] load_of(input logic [TICK_W-1:0] ticks);
        load_of = (ticks == '0) ? '0 : ticks - 1'b1;
    endfunction

endpackage

`default_nettype wire

// ----- design/ssi_efr_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ssi_efr_cfg
    import ssi_efr_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               wr_en,
    input  wire logic [INDEX_W-1:0] wr_index,
    input  wire logic [TICK_W-1:0]  wr_data,
    output cfg_t                    cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (wr_index)
                CFG_LEAD: cfg_next.lead_ticks       = wr_data;
                CFG_HIGH: cfg_next.clock_high_ticks = wr_data;
                CFG_LOW:  cfg_next.clock_low_ticks  = wr_data;
                CFG_GAP:  cfg_next.gap_ticks        = wr_data;
                default:  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.lead_ticks       <= LEAD_RST;
            cfg_reg.clock_high_ticks <= HIGH_RST;
            cfg_reg.clock_low_ticks  <= LOW_RST;
            cfg_reg.gap_ticks        <= GAP_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- design/ssi_efr_seq.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ssi_efr_seq
    import ssi_efr_pkg::*;
#(
    parameter int FRAME_BITS = 18,
    parameter int CHANNELS   = 4
)
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     step,
    input  in_item_t      item,
    input  cfg_t          cfg,
    output out_item_t     result
);

    localparam int CNT_W  = $clog2(FRAME_BITS + 1);
    localparam int WORD_W = (FRAME_BITS > 18) ? FRAME_BITS : 18;
    localparam logic [LINES-1:0] ALL_LINES =
        (CHANNELS >= LINES) ? {LINES{1'b1}} : LINES'((1 << CHANNELS) - 1);

    typedef enum logic [2:0] {
        PH_IDLE = 3'd0,
        PH_LEAD = 3'd1,
        PH_LOW0 = 3'd2,
        PH_HIGH = 3'd3,
        PH_LOW  = 3'd4,
        PH_GAP  = 3'd5
    } phase_t;

    phase_t                phase_reg, phase_next;
    logic [TICK_W-1:0]     wait_reg, wait_next;
    logic [CNT_W-1:0]      bits_reg, bits_next;
    logic [FRAME_BITS-1:0] shift_reg, shift_next;
    logic [1:0]            chan_reg, chan_next;
    logic                  frame_done;
    logic [WORD_W-1:0]     word;
    logic [LINES-1:0]      me;
    logic                  chan_ok;

    assign chan_ok = (int'(item.channel) < CHANNELS);
    assign word    = WORD_W'(shift_reg) >> 1;

    always_comb
    begin
        phase_next = phase_reg;
        wait_next  = wait_reg;
        bits_next  = bits_reg;
        shift_next = shift_reg;
        chan_next  = chan_reg;
        frame_done = 1'b0;
        if (step)
        begin
            if (phase_reg == PH_IDLE)
            begin
                if (item.start_req && chan_ok)
                begin
                    chan_next  = item.channel;
                    bits_next  = '0;
                    shift_next = '0;
                    phase_next = PH_LEAD;
                    wait_next  = load_of(cfg.lead_ticks);
                end
            end
            else if (wait_reg != '0)
            begin
                wait_next = wait_reg - 1'b1;
            end
            else
            begin
                unique case (phase_reg)
                    PH_LEAD:
                    begin
                        phase_next = PH_LOW0;
                        wait_next  = load_of(cfg.lead_ticks);
                    end
                    PH_LOW0:
                    begin
                        phase_next = PH_HIGH;
                        wait_next  = load_of(cfg.clock_high_ticks);
                    end
                    PH_HIGH:
                    begin
                        // sample on the last high tick, MSB first
                        shift_next = {shift_reg[FRAME_BITS-2:0], item.data_pins[chan_reg]};
                        phase_next = PH_LOW;
                        wait_next  = load_of(cfg.clock_low_ticks);
                    end
                    PH_LOW:
                    begin
                        bits_next = bits_reg + 1'b1;
                        if (bits_next >= CNT_W'(FRAME_BITS))
                        begin
                            frame_done = 1'b1;
                            phase_next = PH_GAP;
                            wait_next  = load_of(cfg.gap_ticks);
                        end
                        else
                        begin
                            phase_next = PH_HIGH;
                            wait_next  = load_of(cfg.clock_high_ticks);
                        end
                    end
                    default:
                    begin
                        phase_next = PH_IDLE;
                        wait_next  = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            wait_reg  <= '0;
            bits_reg  <= '0;
            shift_reg <= '0;
            chan_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            wait_reg  <= wait_next;
            bits_reg  <= bits_next;
            shift_reg <= shift_next;
            chan_reg  <= chan_next;
        end
    end

    // result shows the state after this tick
    always_comb
    begin
        me                     = LINES'(1) << chan_next;
        result.clock_lines     = ALL_LINES;
        result.select_lines    = ALL_LINES;
        if (phase_next == PH_LEAD || phase_next == PH_LOW0 ||
            phase_next == PH_HIGH || phase_next == PH_LOW)
            result.select_lines = ALL_LINES & ~me;
        if (phase_next == PH_LOW0 || phase_next == PH_LOW)
            result.clock_lines = ALL_LINES & ~me;
        result.busy_res        = (phase_next != PH_IDLE);
        result.frame_valid     = frame_done;
        result.position        = frame_done ? word[16:5] : '0;
        result.offset_done     = frame_done & word[4];
        result.linearity_flag  = frame_done & word[3];
        result.field_increase  = frame_done & word[2];
        result.field_decrease  = frame_done & word[1];
    end

    a_bits_bound: assert property (@(posedge clk) disable iff (!rst_n)
        bits_reg <= CNT_W'(FRAME_BITS))
        else $error("bit count past frame length");

    a_gap_full: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_GAP |-> bits_reg == CNT_W'(FRAME_BITS))
        else $error("gap entered before all bits received");

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !step |=> $stable(phase_reg) && $stable(wait_reg) && $stable(shift_reg))
        else $error("sequencer moved without an item");

    a_idle_stays: assert property (@(posedge clk) disable iff (!rst_n)
        step && phase_reg == PH_IDLE && !item.start_req |=> phase_reg == PH_IDLE)
        else $error("left idle without a start");

endmodule

`default_nettype wire

// ----- design/ssi_efr_ostage.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ssi_efr_ostage
    import ssi_efr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic load,
    input  out_item_t data,
    output wire logic can_load,
    output wire logic out_valid,
    input  wire logic out_ready,
    output out_item_t out_data
);

    logic      valid_reg, valid_next;
    out_item_t data_reg;

    // a waiting item is replaced in the same cycle it is taken
    assign can_load   = !valid_reg || out_ready;
    assign valid_next = load ? 1'b1 : (valid_reg && !out_ready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            data_reg <= data;
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

`default_nettype wire

// ----- design/ssi_encoder_frame_reader_unit.sv -----
`timescale 1ns / 1ps
`default_nettype none

// SSI master for up to four absolute encoders, one req item per time tick.
// Each accepted item advances the pin sequencer by one tick and yields exactly
// one res item with the line levels and, on the tick the frame completes, the
// unpacked position and status flags. An item is accepted every clock cycle;
// the sequencer state update and result logic sit in front of a single output
// register, so req_ready drops only while that register holds a res item that
// has not been taken. Configuration writes are always accepted (cfg_ready high);
// indexes beyond the four tick registers are ignored.

module ssi_encoder_frame_reader_unit
    import ssi_efr_pkg::*;
#(
    parameter int FRAME_BITS = 18,
    parameter int CHANNELS   = 4
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               req_valid,
    output wire logic               req_ready,
    input  in_item_t                req,
    output wire logic               res_valid,
    input  wire logic               res_ready,
    output out_item_t               res,
    input  wire logic               cfg_valid,
    output wire logic               cfg_ready,
    input  wire logic [INDEX_W-1:0] cfg_index,
    input  wire logic [TICK_W-1:0]  cfg_data
);

    cfg_t      cfg;
    out_item_t result;
    logic      step;

    assign cfg_ready = 1'b1;
    assign step      = req_valid && req_ready;

    ssi_efr_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (cfg_valid && cfg_ready),
        .wr_index (cfg_index),
        .wr_data  (cfg_data),
        .cfg      (cfg)
    );

    ssi_efr_seq #(
        .FRAME_BITS (FRAME_BITS),
        .CHANNELS   (CHANNELS)
    ) u_seq (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (req),
        .cfg    (cfg),
        .result (result)
    );

    ssi_efr_ostage u_ostage (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (step),
        .data      (result),
        .can_load  (req_ready),
        .out_valid (res_valid),
        .out_ready (res_ready),
        .out_data  (res)
    );

endmodule

`default_nettype wire

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
    import ssi_efr_pkg::*;

    localparam int FRAME_LEN     = 18;
    localparam int CHANNEL_COUNT = 4;
    localparam int STALL_LIMIT   = 3000;
    localparam int SQUEEZE_LEN   = 160;
    localparam int SETTLE_CYCLES = 8;

    // data pin patterns for a run of ticks
    localparam int PINS_RANDOM = 0;
    localparam int PINS_LOW    = 1;
    localparam int PINS_HIGH   = 2;

    typedef enum logic [2:0] {
        SEQ_IDLE,
        SEQ_LEAD,
        SEQ_FIRST_LOW,
        SEQ_CLK_HIGH,
        SEQ_CLK_LOW,
        SEQ_GAP
    } seq_phase_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic               req_valid = 1'b0;
    logic               req_ready;
    in_item_t           req = '0;
    logic               res_valid;
    logic               res_ready = 1'b0;
    out_item_t          res;
    logic               cfg_valid = 1'b0;
    logic               cfg_ready;
    logic [INDEX_W-1:0] cfg_index = '0;
    logic [TICK_W-1:0]  cfg_data = '0;

    ssi_encoder_frame_reader_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // sequencer copy kept by the testbench
    cfg_t              regs = '{LEAD_RST, HIGH_RST, LOW_RST, GAP_RST};
    seq_phase_t        seq_phase = SEQ_IDLE;
    logic [TICK_W-1:0] tick_wait = '0;
    logic [4:0]        bits_done = '0;
    logic [17:0]       frame_shift = '0;
    logic [1:0]        chan_sel = '0;

    in_item_t  pending_ticks[$];
    out_item_t expected_lines[$];

    int ticks_queued = 0;
    int ticks_accepted = 0;
    int lines_checked = 0;
    int frames_checked = 0;
    int reg_writes = 0;
    int errors = 0;
    int stall_cycles = 0;

    bit sender_calm = 1'b0;
    bit receiver_calm = 1'b0;

    int send_idle = 0;
    int recv_idle = 0;
    int squeeze_left = 0;
    int recv_count = 0;

    initial begin
        forever #4 clk = ~clk;
    end

    function automatic int gap_len(input bit calm);
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65)
            return 0;
        else if (r < 93)
            return $urandom_range(1, 3);
        else
            return $urandom_range(6, 30);
    endfunction

    function automatic logic [TICK_W-1:0] countdown_for(input logic [TICK_W-1:0] ticks);
        return (ticks > 8'd1) ? ticks - 8'd1 : 8'd0;
    endfunction

    // one tick of the pin sequencer; returns the line levels after the tick
    function automatic out_item_t advance_sequencer(input in_item_t t);
        out_item_t r;
        logic finished;
        r = '0;
        finished = 1'b0;
        if (seq_phase == SEQ_IDLE) begin
            if (t.start_req && t.channel < CHANNEL_COUNT) begin
                chan_sel = t.channel;
                bits_done = '0;
                frame_shift = '0;
                seq_phase = SEQ_LEAD;
                tick_wait = countdown_for(regs.lead_ticks);
            end
        end
        else if (tick_wait != 0) begin
            tick_wait = tick_wait - 1'b1;
        end
        else begin
            case (seq_phase)
                SEQ_LEAD:
                begin
                    seq_phase = SEQ_FIRST_LOW;
                    tick_wait = countdown_for(regs.lead_ticks);
                end
                SEQ_FIRST_LOW:
                begin
                    seq_phase = SEQ_CLK_HIGH;
                    tick_wait = countdown_for(regs.clock_high_ticks);
                end
                SEQ_CLK_HIGH:
                begin
                    frame_shift = {frame_shift[16:0], t.data_pins[chan_sel]};
                    seq_phase = SEQ_CLK_LOW;
                    tick_wait = countdown_for(regs.clock_low_ticks);
                end
                SEQ_CLK_LOW:
                begin
                    bits_done = bits_done + 1'b1;
                    if (bits_done >= FRAME_LEN) begin
                        finished = 1'b1;
                        seq_phase = SEQ_GAP;
                        tick_wait = countdown_for(regs.gap_ticks);
                    end
                    else begin
                        seq_phase = SEQ_CLK_HIGH;
                        tick_wait = countdown_for(regs.clock_high_ticks);
                    end
                end
                default:
                begin
                    seq_phase = SEQ_IDLE;
                    tick_wait = '0;
                end
            endcase
        end

        r.clock_lines = '1;
        r.select_lines = '1;
        if (seq_phase != SEQ_IDLE && seq_phase != SEQ_GAP)
            r.select_lines[chan_sel] = 1'b0;
        if (seq_phase == SEQ_FIRST_LOW || seq_phase == SEQ_CLK_LOW)
            r.clock_lines[chan_sel] = 1'b0;
        r.busy_res = (seq_phase != SEQ_IDLE);
        r.frame_valid = finished;
        // last bit shifted in is dropped, so the frame sits one place higher
        if (finished) begin
            r.position = frame_shift[17:6];
            r.offset_done = frame_shift[5];
            r.linearity_flag = frame_shift[4];
            r.field_increase = frame_shift[3];
            r.field_decrease = frame_shift[2];
        end
        return r;
    endfunction

    task automatic note_mismatch(input string field, input logic [31:0] want,
                                 input logic [31:0] got);
        errors++;
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, field, want, got);
    endtask

    task automatic check_lines(input out_item_t want, input out_item_t got);
        if (got.clock_lines !== want.clock_lines)
            note_mismatch("clock_lines", want.clock_lines, got.clock_lines);
        if (got.select_lines !== want.select_lines)
            note_mismatch("select_lines", want.select_lines, got.select_lines);
        if (got.busy_res !== want.busy_res)
            note_mismatch("busy_res", want.busy_res, got.busy_res);
        if (got.frame_valid !== want.frame_valid)
            note_mismatch("frame_valid", want.frame_valid, got.frame_valid);
        if (got.position !== want.position)
            note_mismatch("position", want.position, got.position);
        if (got.offset_done !== want.offset_done)
            note_mismatch("offset_done", want.offset_done, got.offset_done);
        if (got.linearity_flag !== want.linearity_flag)
            note_mismatch("linearity_flag", want.linearity_flag, got.linearity_flag);
        if (got.field_increase !== want.field_increase)
            note_mismatch("field_increase", want.field_increase, got.field_increase);
        if (got.field_decrease !== want.field_decrease)
            note_mismatch("field_decrease", want.field_decrease, got.field_decrease);
    endtask

    // driver: holds each item until taken, then idles or offers the next one
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            req_valid <= 1'b0;
            req <= '0;
            send_idle <= 0;
        end
        else if (!req_valid || req_ready) begin
            if (send_idle != 0) begin
                send_idle <= send_idle - 1;
                req_valid <= 1'b0;
            end
            else if (pending_ticks.size() != 0) begin
                req <= pending_ticks.pop_front();
                req_valid <= 1'b1;
                send_idle <= gap_len(sender_calm);
            end
            else begin
                req_valid <= 1'b0;
            end
        end
    end

    // receiver: random stalls plus two long hold-offs so the block backs up
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            res_ready <= 1'b0;
            recv_idle <= 0;
            squeeze_left <= 0;
            recv_count <= 0;
        end
        else begin
            if (res_valid && res_ready)
                recv_count <= recv_count + 1;
            if (squeeze_left != 0) begin
                squeeze_left <= squeeze_left - 1;
                res_ready <= 1'b0;
            end
            else if (res_valid && res_ready && (recv_count == 399 || recv_count == 899)) begin
                squeeze_left <= SQUEEZE_LEN;
                res_ready <= 1'b0;
            end
            else if (recv_idle != 0) begin
                recv_idle <= recv_idle - 1;
                res_ready <= 1'b0;
            end
            else begin
                res_ready <= 1'b1;
                recv_idle <= gap_len(receiver_calm);
            end
        end
    end

    // monitor: predict on each accepted tick, check on each accepted result
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (req_valid && req_ready) begin
                expected_lines.push_back(advance_sequencer(req));
                ticks_accepted++;
            end
            if (res_valid && res_ready) begin
                if (expected_lines.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %h", $time, res);
                end
                else begin
                    if (expected_lines[0].frame_valid)
                        frames_checked++;
                    check_lines(expected_lines.pop_front(), res);
                end
                lines_checked++;
            end
        end
    end

    always @(posedge clk)
    begin
        if ((req_valid && req_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    task automatic add_tick(input logic start, input logic [1:0] chan,
                            input logic [LINES-1:0] pins);
        in_item_t t;
        t.start_req = start;
        t.channel = chan;
        t.data_pins = pins;
        pending_ticks.push_back(t);
        ticks_queued++;
    endtask

    task automatic queue_ticks(input int count, input int start_pct, input int pins_mode);
        logic [LINES-1:0] pins;
        for (int i = 0; i < count; i++) begin
            case (pins_mode)
                PINS_LOW:  pins = '0;
                PINS_HIGH: pins = '1;
                default:   pins = LINES'($urandom);
            endcase
            add_tick($urandom_range(0, 99) < start_pct, 2'($urandom_range(0, 3)), pins);
        end
    endtask

    task automatic wait_drained();
        do
            @(negedge clk);
        while (!(ticks_accepted == ticks_queued && expected_lines.size() == 0));
    endtask

    task automatic write_reg(input logic [INDEX_W-1:0] index, input logic [TICK_W-1:0] value);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        reg_writes++;
        case (index)
            CFG_LEAD: regs.lead_ticks = value;
            CFG_HIGH: regs.clock_high_ticks = value;
            CFG_LOW:  regs.clock_low_ticks = value;
            CFG_GAP:  regs.gap_ticks = value;
            default:  ;
        endcase
    endtask

    task automatic program_timing(input cfg_t timing);
        write_reg(CFG_LEAD, timing.lead_ticks);
        write_reg(CFG_HIGH, timing.clock_high_ticks);
        write_reg(CFG_LOW, timing.clock_low_ticks);
        write_reg(CFG_GAP, timing.gap_ticks);
    endtask

    initial begin
        cfg_t timing;
        int count;
        int start_pct;
        int pins_mode;
        logic [INDEX_W-1:0] stray_index;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset timing: idle tick, start on the top channel, start while busy,
        // then pin extremes through lead, first clock low and the first two data bits
        add_tick(1'b0, 2'd3, 4'hF);
        add_tick(1'b1, 2'd3, 4'hF);
        add_tick(1'b1, 2'd0, 4'h0);
        for (int i = 0; i < 17; i++)
            add_tick(i[0], i[1:0], i[0] ? 4'hF : 4'h0);
        wait_drained();

        // writes to an unused index must leave the timing alone
        stray_index = INDEX_W'(4 + $urandom_range(0, 251));
        write_reg(stray_index, TICK_W'($urandom));
        write_reg('1, 8'd0);

        for (int ph = 0; ph < 10; ph++) begin
            start_pct = 50;
            pins_mode = PINS_RANDOM;
            count = 100;
            case (ph)
                0:
                begin
                    timing = '0;
                    pins_mode = PINS_LOW;
                    count = 120;
                end
                1:
                begin
                    timing = '{8'd1, 8'd1, 8'd1, 8'd1};
                    pins_mode = PINS_HIGH;
                    count = 120;
                end
                2:
                begin
                    timing = '1;
                    count = 270;
                end
                3:
                begin
                    timing = '{8'd1, 8'd1, 8'd1, 8'd1};
                    start_pct = 90;
                    count = 60;
                end
                default:
                begin
                    timing.lead_ticks = TICK_W'($urandom_range(0, 3));
                    timing.clock_high_ticks = TICK_W'($urandom_range(0, 3));
                    timing.clock_low_ticks = TICK_W'($urandom_range(0, 3));
                    timing.gap_ticks = TICK_W'($urandom_range(0, 3));
                end
            endcase
            sender_calm = (ph % 4 == 1);
            receiver_calm = (ph % 4 == 2);
            program_timing(timing);
            queue_ticks(count, start_pct, pins_mode);
            wait_drained();
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (expected_lines.size() != 0) begin
            errors++;
            $display("%0t: %0d results never arrived", $time, expected_lines.size());
        end
        $display("Ran %0d ticks through the sequencer, %0d timing writes", ticks_accepted,
                 reg_writes);
        $display("Checked %0d line states, %0d complete frames, %0d errors", lines_checked,
                 frames_checked, errors);
        if (errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
